### hw/rtl/pnsp_pkg.sv
// Shared types and constants for the nearest-segment plan pruner.
// Used by pnsp_ctrl, pnsp_dp and polyline_nearest_segment_prune_top.
package pnsp_pkg;

  localparam int COORD_W = 24;           // signed waypoint coordinate
  localparam int IDX_W   = 5;            // waypoint index / prune count
  localparam int DIFF_W  = 25;           // coordinate difference
  localparam int OPND_W  = 26;           // multiplier operand
  localparam int PROD_W  = 2 * OPND_W;   // multiplier product / accumulators
  localparam int DIST_W  = 52;           // squared distance
  localparam int FRAC_W  = 16;           // fraction bits of t
  localparam int T_W     = FRAC_W + 1;   // t in 0..1.0
  localparam int STEP_W  = 4;

  localparam logic [T_W-1:0]    T_ONE    = T_W'(1) << FRAC_W;
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(6);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(FRAC_W - 1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUTE,
    S_MUL,
    S_CLASSIFY,
    S_DIV,
    S_TMUL,
    S_UPDATE,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_VXX,
    OP_VYY,
    OP_VZZ,
    OP_WXV,
    OP_WYV,
    OP_WZV,
    OP_TVX,
    OP_TVY,
    OP_TVZ,
    OP_DXX,
    OP_DYY,
    OP_DZZ
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    set_t0;
    logic    set_t1;
    logic    div_start;
    logic    div_step;
    logic    update;
    logic    emit;
    mul_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_point;
    logic seg_en;
    logic last;
    logic vsq_zero;
    logic dot_le0;
    logic dot_ge;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/polyline_nearest_segment_prune_top.sv
// Nearest-segment plan pruner, top level.
// Depends on pnsp_pkg, pnsp_ctrl and pnsp_dp.
//
// Takes one request at a time. A start request and a waypoint that closes
// no segment only pass through routing; a zero-length segment stops after
// the squared-length and dot products; a segment whose projection clamps
// to an end adds the projection and distance products; an interior
// projection also runs the 16-step restoring divider for t. A waypoint
// marked last then loads the result register once any earlier result is
// taken; the result holds until taken while the next request is already
// accepted. Per-segment cost is set by the single shared 26x26 multiplier
// (up to twelve products per segment) and the one-bit-per-cycle divider.
module polyline_nearest_segment_prune_top #(
  parameter int SEARCH_DEPTH = 30
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic signed [pnsp_pkg::COORD_W-1:0] pos_x,
  input  logic signed [pnsp_pkg::COORD_W-1:0] pos_y,
  input  logic signed [pnsp_pkg::COORD_W-1:0] pos_z,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pnsp_pkg::IDX_W-1:0]          prune_count
);
  import pnsp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pnsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pnsp_dp #(
    .SEARCH_DEPTH (SEARCH_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .last_point  (last_point),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prune_count (prune_count)
  );

endmodule

### hw/rtl/pnsp_ctrl.sv
// Sequencer for the nearest-segment plan pruner.
// Depends on pnsp_pkg; drives pnsp_dp through ctrl_cmd_t.
module pnsp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pnsp_pkg::dp_status_t  status,
  output pnsp_pkg::ctrl_cmd_t   cmd
);
  import pnsp_pkg::*;

  state_t              state, state_next;
  logic [STEP_W-1:0]   step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.set_t0    = 1'b0;
    cmd.set_t1    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.update    = 1'b0;
    cmd.emit      = 1'b0;
    cmd.op        = OP_NONE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        step_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (!status.is_point) state_next = S_IDLE;
        else if (status.seg_en) state_next = S_MUL;
        else if (status.last) state_next = S_FINISH;
        else state_next = S_IDLE;
      end
      S_MUL: begin
        unique case (step)
          STEP_W'(0): cmd.op = OP_VXX;
          STEP_W'(1): cmd.op = OP_VYY;
          STEP_W'(2): cmd.op = OP_VZZ;
          STEP_W'(3): cmd.op = OP_WXV;
          STEP_W'(4): cmd.op = OP_WYV;
          STEP_W'(5): cmd.op = OP_WZV;
          default:    cmd.op = OP_NONE;
        endcase
        if (step == MUL_LAST) begin
          step_next  = '0;
          state_next = S_CLASSIFY;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_CLASSIFY: begin
        if (status.vsq_zero) begin
          state_next = status.last ? S_FINISH : S_IDLE;
        end else if (status.dot_le0) begin
          cmd.set_t0 = 1'b1;
          state_next = S_TMUL;
        end else if (status.dot_ge) begin
          cmd.set_t1 = 1'b1;
          state_next = S_TMUL;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = S_TMUL;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_TMUL: begin
        unique case (step)
          STEP_W'(0): cmd.op = OP_TVX;
          STEP_W'(1): cmd.op = OP_TVY;
          STEP_W'(2): cmd.op = OP_TVZ;
          STEP_W'(3): cmd.op = OP_DXX;
          STEP_W'(4): cmd.op = OP_DYY;
          STEP_W'(5): cmd.op = OP_DZZ;
          default:    cmd.op = OP_NONE;
        endcase
        if (step == MUL_LAST) begin
          step_next  = '0;
          state_next = S_UPDATE;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.last ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == DIV_LAST) |=> (state == S_TMUL && step == '0))
    else $error("divider did not hand over to projection");

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.last)
    else $error("result emitted for a request not marked last");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready)
    else $error("second request taken while one is in work");

endmodule

### hw/rtl/pnsp_dp.sv
// Datapath: plan state, shared 26x26 multiplier, restoring t divider,
// best-segment compare and output register. Depends on pnsp_pkg.
module pnsp_dp #(
  parameter int SEARCH_DEPTH = 30
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pnsp_pkg::ctrl_cmd_t                cmd,
  output pnsp_pkg::dp_status_t               status,
  input  logic                               command,
  input  logic signed [pnsp_pkg::COORD_W-1:0] pos_x,
  input  logic signed [pnsp_pkg::COORD_W-1:0] pos_y,
  input  logic signed [pnsp_pkg::COORD_W-1:0] pos_z,
  input  logic                               last_point,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pnsp_pkg::IDX_W-1:0]         prune_count
);
  import pnsp_pkg::*;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(SEARCH_DEPTH);

  logic signed [COORD_W-1:0] robot_x, robot_y, robot_z;
  logic signed [COORD_W-1:0] prev_x, prev_y, prev_z;
  logic [IDX_W-1:0]          points_seen;
  logic [DIST_W-1:0]         best_dist_sq;
  logic [IDX_W-1:0]          best_index;

  logic [IDX_W-1:0]          seg_idx;
  logic                      seg_en, is_point, last_r;
  logic signed [DIFF_W-1:0]  vx, vy, vz, wx, wy, wz, dx, dy, dz;
  logic signed [OPND_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod, v_sq, dot;
  mul_op_t                   prod_op;
  logic [DIST_W-1:0]         d_sq, rem, rem_shift;
  logic [T_W-1:0]            t;
  logic signed [PROD_W:0]    dot2, vsq_ext;
  logic                      behind, closer;

  function automatic logic signed [DIFF_W-1:0] proj_diff(
    input logic signed [DIFF_W-1:0] w,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] off;
    logic signed [DIFF_W:0]   d;
    adj = p[PROD_W-1] ? (p + PROD_W'((1 << FRAC_W) - 1)) : p;
    off = adj >>> FRAC_W;
    d   = (DIFF_W+1)'(w) - (DIFF_W+1)'(off);
    return d[DIFF_W-1:0];
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_VXX: begin mul_a = OPND_W'(vx); mul_b = OPND_W'(vx); end
      OP_VYY: begin mul_a = OPND_W'(vy); mul_b = OPND_W'(vy); end
      OP_VZZ: begin mul_a = OPND_W'(vz); mul_b = OPND_W'(vz); end
      OP_WXV: begin mul_a = OPND_W'(wx); mul_b = OPND_W'(vx); end
      OP_WYV: begin mul_a = OPND_W'(wy); mul_b = OPND_W'(vy); end
      OP_WZV: begin mul_a = OPND_W'(wz); mul_b = OPND_W'(vz); end
      OP_TVX: begin mul_a = signed'(OPND_W'(t)); mul_b = OPND_W'(vx); end
      OP_TVY: begin mul_a = signed'(OPND_W'(t)); mul_b = OPND_W'(vy); end
      OP_TVZ: begin mul_a = signed'(OPND_W'(t)); mul_b = OPND_W'(vz); end
      OP_DXX: begin mul_a = OPND_W'(dx); mul_b = OPND_W'(dx); end
      OP_DYY: begin mul_a = OPND_W'(dy); mul_b = OPND_W'(dy); end
      OP_DZZ: begin mul_a = OPND_W'(dz); mul_b = OPND_W'(dz); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign rem_shift = {rem[DIST_W-2:0], 1'b0};
  assign dot2      = {dot, 1'b0};
  assign vsq_ext   = {v_sq[PROD_W-1], v_sq};
  assign behind    = dot2 >= vsq_ext;
  assign closer    = d_sq < best_dist_sq;

  // multiplier stage, then accumulate on the registered op
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= OP_NONE;
    end else begin
      prod_op <= cmd.op;
    end
    prod <= mul_a * mul_b;
    case (prod_op)
      OP_VXX: v_sq <= prod;
      OP_VYY, OP_VZZ: v_sq <= v_sq + prod;
      OP_WXV: dot <= prod;
      OP_WYV, OP_WZV: dot <= dot + prod;
      OP_TVX: dx <= proj_diff(wx, prod);
      OP_TVY: dy <= proj_diff(wy, prod);
      OP_TVZ: dz <= proj_diff(wz, prod);
      OP_DXX: d_sq <= DIST_W'(unsigned'(prod));
      OP_DYY, OP_DZZ: d_sq <= d_sq + DIST_W'(unsigned'(prod));
      default: ;
    endcase
  end

  // t: clamp or 16-step restoring division dot / v_sq
  always_ff @(posedge clk) begin
    if (cmd.set_t0) begin
      t <= '0;
    end else if (cmd.set_t1) begin
      t <= T_ONE;
    end else if (cmd.div_start) begin
      t   <= '0;
      rem <= DIST_W'(unsigned'(dot));
    end else if (cmd.div_step) begin
      if (rem_shift >= DIST_W'(unsigned'(v_sq))) begin
        rem <= rem_shift - DIST_W'(unsigned'(v_sq));
        t   <= {t[T_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        t   <= {t[T_W-2:0], 1'b0};
      end
    end
  end

  // per-request latches
  always_ff @(posedge clk) begin
    if (cmd.load && command == CMD_POINT) begin
      vx      <= DIFF_W'(pos_x) - DIFF_W'(prev_x);
      vy      <= DIFF_W'(pos_y) - DIFF_W'(prev_y);
      vz      <= DIFF_W'(pos_z) - DIFF_W'(prev_z);
      wx      <= DIFF_W'(robot_x) - DIFF_W'(prev_x);
      wy      <= DIFF_W'(robot_y) - DIFF_W'(prev_y);
      wz      <= DIFF_W'(robot_z) - DIFF_W'(prev_z);
      seg_idx <= points_seen - IDX_W'(1);
    end
  end

  // plan state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      robot_x      <= '0;
      robot_y      <= '0;
      robot_z      <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      prev_z       <= '0;
      points_seen  <= '0;
      best_dist_sq <= '1;
      best_index   <= '0;
      seg_en       <= 1'b0;
      is_point     <= 1'b0;
      last_r       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (command == CMD_START) begin
          robot_x      <= pos_x;
          robot_y      <= pos_y;
          robot_z      <= pos_z;
          points_seen  <= '0;
          best_dist_sq <= '1;
          best_index   <= '0;
          is_point     <= 1'b0;
          seg_en       <= 1'b0;
          last_r       <= 1'b0;
        end else begin
          prev_x   <= pos_x;
          prev_y   <= pos_y;
          prev_z   <= pos_z;
          is_point <= 1'b1;
          last_r   <= last_point;
          seg_en   <= (points_seen != '0) && (points_seen < MAX_IDX);
          if (points_seen < MAX_IDX) begin
            points_seen <= points_seen + IDX_W'(1);
          end
        end
      end
      if (cmd.update && closer) begin
        best_dist_sq <= d_sq;
        best_index   <= behind ? seg_idx + IDX_W'(1) : seg_idx;
      end
      if (cmd.emit) begin
        out_valid    <= 1'b1;
        points_seen  <= '0;
        best_dist_sq <= '1;
        best_index   <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      prune_count <= best_index;
    end
  end

  assign status.is_point = is_point;
  assign status.seg_en   = seg_en;
  assign status.last     = last_r;
  assign status.vsq_zero = (v_sq == '0);
  assign status.dot_le0  = dot[PROD_W-1] || (dot == '0);
  assign status.dot_ge   = (dot >= v_sq);
  assign status.out_free = !out_valid || out_ready;

  assert property (@(posedge clk) disable iff (rst)
    best_index <= points_seen)
    else $error("best index ahead of waypoints seen");

  assert property (@(posedge clk) disable iff (rst)
    (points_seen == '0) |-> (best_dist_sq == '1))
    else $error("search not cleared");

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrites pending result");

  assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (t <= T_ONE))
    else $error("projection parameter out of range");

endmodule
